// ===== hdl/tpqm_pkg.sv =====
`timescale 1ns / 1ps
package tpqm_pkg;

  localparam int SAMPLE_W = 12;
  localparam int HOLD_W   = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W    = 5;

  // Screen size in pixels.
  localparam logic [SAMPLE_W-1:0] WIDTH  = 12'd240;
  localparam logic [SAMPLE_W-1:0] HEIGHT = 12'd320;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_CAL_X_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_X_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_THR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_MODE    = 3'd6;

  // Register reset values.
  localparam logic [SAMPLE_W-1:0] RST_CAL_X_LOW  = 12'd300;
  localparam logic [SAMPLE_W-1:0] RST_CAL_X_HIGH = 12'd3800;
  localparam logic [SAMPLE_W-1:0] RST_CAL_Y_LOW  = 12'd260;
  localparam logic [SAMPLE_W-1:0] RST_CAL_Y_HIGH = 12'd3800;
  localparam logic [SAMPLE_W-1:0] RST_PRESS_THR  = 12'd800;
  localparam logic [HOLD_W-1:0]   RST_HOLDOFF    = 10'd200;

  // Input command codes.
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Last step count of the serial multiply (one multiplier bit a cycle) and
  // of the serial divide (one quotient bit a cycle over the 24-bit product).
  localparam logic [CNT_W-1:0] MUL_LAST = 5'd11;
  localparam logic [CNT_W-1:0] DIV_LAST = 5'd23;

endpackage

// ===== hdl/tpqm_if.sv =====
`timescale 1ns / 1ps
interface tpqm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [tpqm_pkg::SAMPLE_W-1:0] sample_x;
  logic [tpqm_pkg::SAMPLE_W-1:0] sample_y;
  logic [tpqm_pkg::SAMPLE_W-1:0] sample_pressure;

  modport source (output valid, cmd, sample_x, sample_y, sample_pressure, input ready);
  modport sink (input valid, cmd, sample_x, sample_y, sample_pressure, output ready);
endinterface

interface tpqm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          touched;
  logic [tpqm_pkg::SAMPLE_W-1:0] point_x;
  logic [tpqm_pkg::SAMPLE_W-1:0] point_y;

  modport source (output valid, touched, point_x, point_y, input ready);
  modport sink (input valid, touched, point_x, point_y, output ready);
endinterface

// ===== hdl/touch_point_qualify_and_map.sv =====
`timescale 1ns / 1ps
// Touch sample qualifier and screen mapper. A tick transfer (cmd 0) counts
// the post-touch holdoff down and gives no result; every sample transfer
// (cmd 1) gives exactly one result, which is zero unless the sample confirms
// a touch. A confirmed touch in calibrated mode runs both axes through one
// shared bit-serial unit: per axis a setup step, a shift-add multiply, a
// restoring divide and a mapping step. Results leave through an output
// register, so the next item is taken while a result still waits.
// The user must write the configuration registers through cfg_we, cfg_index
// and cfg_data only while the block is idle; the block does not enforce it.
module touch_point_qualify_and_map (
  input  logic                           clk,
  input  logic                           rst_n,
  tpqm_in_if.sink                        in_ch,
  tpqm_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [tpqm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpqm_pkg::SAMPLE_W-1:0]  cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_MAP   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  localparam int SW = tpqm_pkg::SAMPLE_W;
  localparam int HW = tpqm_pkg::HOLD_W;
  localparam int CW = tpqm_pkg::CNT_W;
  localparam int PW = 2 * tpqm_pkg::SAMPLE_W;

  logic [2:0]    state_r, state_nxt;
  logic [SW-1:0] cal_x_low_r, cal_x_low_nxt;
  logic [SW-1:0] cal_x_high_r, cal_x_high_nxt;
  logic [SW-1:0] cal_y_low_r, cal_y_low_nxt;
  logic [SW-1:0] cal_y_high_r, cal_y_high_nxt;
  logic [SW-1:0] press_thr_r, press_thr_nxt;
  logic [HW-1:0] holdoff_ticks_r, holdoff_ticks_nxt;
  logic          raw_mode_r, raw_mode_nxt;
  logic [HW-1:0] holdoff_r, holdoff_nxt;
  logic          armed_r, armed_nxt;

  logic [SW-1:0] sx_r, sx_nxt;
  logic [SW-1:0] sy_r, sy_nxt;
  logic          axis_r, axis_nxt;
  logic [tpqm_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] mcand_r, mcand_nxt;
  logic [SW-1:0] hi_r, hi_nxt;
  logic [SW-1:0] lo_r, lo_nxt;
  logic [SW-1:0] smag_r, smag_nxt;
  logic          neg_r, neg_nxt;
  logic          zspan_r, zspan_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [PW-1:0] q_r, q_nxt;

  logic          res_t_r, res_t_nxt;
  logic [SW-1:0] res_x_r, res_x_nxt;
  logic [SW-1:0] res_y_r, res_y_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_t_r, out_t_nxt;
  logic [SW-1:0] out_x_r, out_x_nxt;
  logic [SW-1:0] out_y_r, out_y_nxt;

  // Axis 0 maps raw y onto the columns, axis 1 maps raw x (inverted) onto
  // the rows.
  logic [SW-1:0] v_sel, a_sel, b_sel, top_sel;
  logic [SW:0]   diff, span;
  logic [SW-1:0] dmag, smag;
  logic [SW:0]   mul_sum;
  logic [SW:0]   rem_sh;
  logic          div_ge;
  logic [SW:0]   rem_sub;
  logic [SW-1:0] mapped;
  logic          pressed;

  assign in_ch.ready    = (state_r == ST_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.touched = out_t_r;
  assign out_ch.point_x = out_x_r;
  assign out_ch.point_y = out_y_r;

  assign pressed = (in_ch.sample_pressure > press_thr_r);

  always_comb begin
    v_sel   = axis_r ? sx_r : sy_r;
    a_sel   = axis_r ? cal_x_high_r : cal_y_low_r;
    b_sel   = axis_r ? cal_x_low_r : cal_y_high_r;
    top_sel = axis_r ? tpqm_pkg::HEIGHT : tpqm_pkg::WIDTH;
    diff    = {1'b0, v_sel} - {1'b0, a_sel};
    span    = {1'b0, b_sel} - {1'b0, a_sel};
    dmag    = diff[SW] ? SW'(-diff) : diff[SW-1:0];
    smag    = span[SW] ? SW'(-span) : span[SW-1:0];
  end

  // One multiplier bit per cycle, least significant first.
  assign mul_sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : '0);

  // One quotient bit per cycle, numerator bits enter from the top of q_r.
  assign rem_sh  = {rem_r, q_r[PW-1]};
  assign div_ge  = (rem_sh >= {1'b0, smag_r});
  assign rem_sub = rem_sh - {1'b0, smag_r};

  // A negative quotient or a zero span clamps to the first pixel.
  always_comb begin
    if (zspan_r || neg_r) begin
      mapped = SW'(1);
    end else if (q_r >= {{SW{1'b0}}, top_sel}) begin
      mapped = top_sel;
    end else begin
      mapped = q_r[SW-1:0] + SW'(1);
    end
  end

  always_comb begin
    state_nxt         = state_r;
    cal_x_low_nxt     = cal_x_low_r;
    cal_x_high_nxt    = cal_x_high_r;
    cal_y_low_nxt     = cal_y_low_r;
    cal_y_high_nxt    = cal_y_high_r;
    press_thr_nxt     = press_thr_r;
    holdoff_ticks_nxt = holdoff_ticks_r;
    raw_mode_nxt      = raw_mode_r;
    holdoff_nxt       = holdoff_r;
    armed_nxt         = armed_r;
    sx_nxt            = sx_r;
    sy_nxt            = sy_r;
    axis_nxt          = axis_r;
    cnt_nxt           = cnt_r;
    mcand_nxt         = mcand_r;
    hi_nxt            = hi_r;
    lo_nxt            = lo_r;
    smag_nxt          = smag_r;
    neg_nxt           = neg_r;
    zspan_nxt         = zspan_r;
    rem_nxt           = rem_r;
    q_nxt             = q_r;
    res_t_nxt         = res_t_r;
    res_x_nxt         = res_x_r;
    res_y_nxt         = res_y_r;
    out_valid_nxt     = out_valid_r;
    out_t_nxt         = out_t_r;
    out_x_nxt         = out_x_r;
    out_y_nxt         = out_y_r;

    if (cfg_we) begin
      case (cfg_index)
        tpqm_pkg::REG_CAL_X_LOW:  cal_x_low_nxt = cfg_data;
        tpqm_pkg::REG_CAL_X_HIGH: cal_x_high_nxt = cfg_data;
        tpqm_pkg::REG_CAL_Y_LOW:  cal_y_low_nxt = cfg_data;
        tpqm_pkg::REG_CAL_Y_HIGH: cal_y_high_nxt = cfg_data;
        tpqm_pkg::REG_PRESS_THR:  press_thr_nxt = cfg_data;
        tpqm_pkg::REG_HOLDOFF:    holdoff_ticks_nxt = cfg_data[HW-1:0];
        tpqm_pkg::REG_RAW_MODE:   raw_mode_nxt = cfg_data[0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.cmd == tpqm_pkg::CMD_TICK) begin
            if (holdoff_r != '0) begin
              holdoff_nxt = holdoff_r - HW'(1);
            end
          end else begin
            sx_nxt    = in_ch.sample_x;
            sy_nxt    = in_ch.sample_y;
            res_t_nxt = 1'b0;
            res_x_nxt = '0;
            res_y_nxt = '0;
            state_nxt = ST_EMIT;
            if (holdoff_r == '0) begin
              if (!armed_r) begin
                armed_nxt = pressed;
              end else begin
                armed_nxt = 1'b0;
                if (pressed) begin
                  holdoff_nxt = holdoff_ticks_r;
                  res_t_nxt   = 1'b1;
                  if (raw_mode_r) begin
                    res_x_nxt = in_ch.sample_x;
                    res_y_nxt = in_ch.sample_y;
                  end else begin
                    axis_nxt  = 1'b0;
                    state_nxt = ST_SETUP;
                  end
                end
              end
            end
          end
        end
      end
      ST_SETUP: begin
        mcand_nxt = top_sel - SW'(1);
        hi_nxt    = '0;
        lo_nxt    = dmag;
        smag_nxt  = smag;
        neg_nxt   = diff[SW] ^ span[SW];
        zspan_nxt = (span == '0);
        cnt_nxt   = tpqm_pkg::MUL_LAST;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        hi_nxt = mul_sum[SW:1];
        lo_nxt = {mul_sum[0], lo_r[SW-1:1]};
        if (cnt_r == '0) begin
          q_nxt     = {mul_sum[SW:1], mul_sum[0], lo_r[SW-1:1]};
          rem_nxt   = '0;
          cnt_nxt   = tpqm_pkg::DIV_LAST;
          state_nxt = ST_DIV;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      ST_DIV: begin
        rem_nxt = div_ge ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
        q_nxt   = {q_r[PW-2:0], div_ge};
        if (cnt_r == '0) begin
          state_nxt = ST_MAP;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      ST_MAP: begin
        if (!axis_r) begin
          res_x_nxt = mapped;
          axis_nxt  = 1'b1;
          state_nxt = ST_SETUP;
        end else begin
          res_y_nxt = mapped;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_t_nxt     = res_t_r;
          out_x_nxt     = res_x_r;
          out_y_nxt     = res_y_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      cal_x_low_r     <= tpqm_pkg::RST_CAL_X_LOW;
      cal_x_high_r    <= tpqm_pkg::RST_CAL_X_HIGH;
      cal_y_low_r     <= tpqm_pkg::RST_CAL_Y_LOW;
      cal_y_high_r    <= tpqm_pkg::RST_CAL_Y_HIGH;
      press_thr_r     <= tpqm_pkg::RST_PRESS_THR;
      holdoff_ticks_r <= tpqm_pkg::RST_HOLDOFF;
      raw_mode_r      <= 1'b0;
      holdoff_r       <= '0;
      armed_r         <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      cal_x_low_r     <= cal_x_low_nxt;
      cal_x_high_r    <= cal_x_high_nxt;
      cal_y_low_r     <= cal_y_low_nxt;
      cal_y_high_r    <= cal_y_high_nxt;
      press_thr_r     <= press_thr_nxt;
      holdoff_ticks_r <= holdoff_ticks_nxt;
      raw_mode_r      <= raw_mode_nxt;
      holdoff_r       <= holdoff_nxt;
      armed_r         <= armed_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    axis_r  <= axis_nxt;
    cnt_r   <= cnt_nxt;
    mcand_r <= mcand_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
    smag_r  <= smag_nxt;
    neg_r   <= neg_nxt;
    zspan_r <= zspan_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    res_t_r <= res_t_nxt;
    res_x_r <= res_x_nxt;
    res_y_r <= res_y_nxt;
    out_t_r <= out_t_nxt;
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
  end

endmodule

// ===== hdl/tpqm_checker.sv =====
`timescale 1ns / 1ps
module tpqm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_touched,
  input logic [tpqm_pkg::SAMPLE_W-1:0] out_point_x,
  input logic [tpqm_pkg::SAMPLE_W-1:0] out_point_y
);

  logic out_xfer;
  logic last_touched_r;

  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_touched_r <= 1'b0;
    end else if (out_xfer) begin
      last_touched_r <= out_touched;
    end
  end

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before its transfer");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_touched) && $stable(out_point_x)
      && $stable(out_point_y))
    else $error("result payload changed while stalled");

  // A result without a confirmed touch carries a zero point.
  a_untouched_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_touched |-> out_point_x == '0 && out_point_y == '0)
    else $error("untouched result with nonzero point");

  // A confirmed touch disarms, so the next confirmation needs a new arming
  // sample, which always reports untouched.
  a_no_double_touch: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_touched |-> !last_touched_r)
    else $error("two confirmed touches in a row");

endmodule

bind touch_point_qualify_and_map tpqm_checker u_tpqm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_touched (out_ch.touched),
  .out_point_x (out_ch.point_x),
  .out_point_y (out_ch.point_y)
);

// ===== verif/tb_touch_point_qualify_and_map.sv =====
`timescale 1ns / 1ps
module tb_touch_point_qualify_and_map;

  localparam int SW = tpqm_pkg::SAMPLE_W;
  localparam int HW = tpqm_pkg::HOLD_W;
  localparam int IW = tpqm_pkg::CFG_IDX_W;

  localparam int RANDOM_ITEMS   = 500;
  localparam int PHASE_ITEMS    = 40;
  localparam int SETTLE_CYCLES  = 100;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int NUM_STEPS      = 38;
  localparam logic [IW-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic          touched;
    logic [SW-1:0] point_x;
    logic [SW-1:0] point_y;
  } touch_result_t;

  localparam touch_result_t NO_POINT = '0;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t      kind;
    logic           cmd;
    logic [IW-1:0]  reg_idx;
    logic [SW-1:0]  x;  // register data on a register row
    logic [SW-1:0]  y;
    logic [SW-1:0]  p;
    int             reps;
    logic           typed;
    touch_result_t  want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic          cfg_we;
  logic [IW-1:0] cfg_index;
  logic [SW-1:0] cfg_data;

  tpqm_in_if  in_ch ();
  tpqm_out_if out_ch ();

  touch_point_qualify_and_map DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow copy of the block's registers and qualifier state.
  logic [SW-1:0] cal_x_lo, cal_x_hi, cal_y_lo, cal_y_hi, press_thr;
  logic [HW-1:0] hold_ticks, holdoff_left;
  logic          raw_sel, armed;

  touch_result_t expected_points[$];
  touch_result_t got_point, want_point;
  int errors        = 0;
  int cycle_count   = 0;
  int items_sent    = 0;
  int stall_left    = 0;
  logic no_idle     = 1'b0;

  stim_row_t steps [NUM_STEPS] = '{
    '{ROW_ITEM, tpqm_pkg::CMD_SAMPLE, 3'd0, 12'd0, 12'd0, 12'd0, 1, 1'b1, NO_POINT},
    '{ROW_ITEM, tpqm_pkg::CMD_SAMPLE, 3'd0, 12'd0, 12'd0, 12'd4095, 1, 1'b1, NO_POINT},
    '{ROW_ITEM, tpqm_pkg::CMD_SAMPLE, 3'd0, 12'd4095, 12'd4095, 12'd801, 1, 1'b1,
      '{1'b1, 12'd240, 12'd1}},
    '{ROW_ITEM, tpqm_pkg::CMD_SAMPLE, 3'd0, 12'd100, 12'd100, 12'd4095, 1, 1'b1, NO_POINT},
    '{ROW_ITEM, tpqm_pkg::CMD_TICK, 3'd0, 12'd0, 12'd0, 12'd0, 199, 1'b0, NO_POINT},
    '{ROW_ITEM, tpqm_pkg::CMD_SAMPLE, 3'd0, 12'd50, 12'd50, 12'd4095, 1, 1'b1, NO_POINT},
    '{ROW_ITEM, tpqm_pkg::CMD_TICK, 3'd0, 12'd0, 12'd0, 12'd0, 2, 1'b0, NO_POINT},
    '{ROW_REG, tpqm_pkg::CMD_TICK, tpqm_pkg::REG_HOLDOFF, 12'd0, 12'd0, 12'd0, 1, 1'b0,
      NO_POINT},
    '{ROW_ITEM, tpqm_pkg::CMD_SAMPLE, 3'd0, 12'd300, 12'd260, 12'd4095, 1, 1'b1, NO_POINT},
    '{ROW_ITEM, tpqm_pkg::CMD_SAMPLE, 3'd0, 12'd300, 12'd260, 12'd4095, 1, 1'b1,
      '{1'b1, 12'd1, 12'd320}},
    '{ROW_ITEM, tpqm_pkg::CMD_SAMPLE, 3'd0, 12'd4095, 12'd4095, 12'd800, 1, 1'b1, NO_POINT},
    '{ROW_ITEM, tpqm_pkg::CMD_SAMPLE, 3'd0, 12'd2000, 12'd2000, 12'd801, 1, 1'b1, NO_POINT},
    '{ROW_ITEM, tpqm_pkg::CMD_SAMPLE, 3'd0, 12'd2000, 12'd2000, 12'd800, 1, 1'b1, NO_POINT},
    '{ROW_REG, tpqm_pkg::CMD_TICK, tpqm_pkg::REG_RAW_MODE, 12'd1, 12'd0, 12'd0, 1, 1'b0,
      NO_POINT},
    '{ROW_ITEM, tpqm_pkg::CMD_SAMPLE, 3'd0, 12'd4095, 12'd0, 12'd4095, 1, 1'b1, NO_POINT},
    '{ROW_ITEM, tpqm_pkg::CMD_SAMPLE, 3'd0, 12'd4095, 12'd0, 12'd4095, 1, 1'b1,
      '{1'b1, 12'd4095, 12'd0}},
    '{ROW_REG, tpqm_pkg::CMD_TICK, tpqm_pkg::REG_RAW_MODE, 12'd0, 12'd0, 12'd0, 1, 1'b0,
      NO_POINT},
    '{ROW_REG, tpqm_pkg::CMD_TICK, tpqm_pkg::REG_CAL_X_LOW, 12'd2000, 12'd0, 12'd0, 1, 1'b0,
      NO_POINT},
    '{ROW_REG, tpqm_pkg::CMD_TICK, tpqm_pkg::REG_CAL_X_HIGH, 12'd2000, 12'd0, 12'd0, 1, 1'b0,
      NO_POINT},
    '{ROW_REG, tpqm_pkg::CMD_TICK, tpqm_pkg::REG_CAL_Y_LOW, 12'd0, 12'd0, 12'd0, 1, 1'b0,
      NO_POINT},
    '{ROW_REG, tpqm_pkg::CMD_TICK, tpqm_pkg::REG_CAL_Y_HIGH, 12'd0, 12'd0, 12'd0, 1, 1'b0,
      NO_POINT},
    '{ROW_ITEM, tpqm_pkg::CMD_SAMPLE, 3'd0, 12'd123, 12'd456, 12'd4095, 1, 1'b1, NO_POINT},
    '{ROW_ITEM, tpqm_pkg::CMD_SAMPLE, 3'd0, 12'd123, 12'd456, 12'd4095, 1, 1'b1,
      '{1'b1, 12'd1, 12'd1}},
    '{ROW_REG, tpqm_pkg::CMD_TICK, tpqm_pkg::REG_PRESS_THR, 12'd4095, 12'd0, 12'd0, 1, 1'b0,
      NO_POINT},
    '{ROW_ITEM, tpqm_pkg::CMD_SAMPLE, 3'd0, 12'd7, 12'd9, 12'd4095, 1, 1'b1, NO_POINT},
    '{ROW_REG, tpqm_pkg::CMD_TICK, tpqm_pkg::REG_PRESS_THR, 12'd0, 12'd0, 12'd0, 1, 1'b0,
      NO_POINT},
    '{ROW_ITEM, tpqm_pkg::CMD_SAMPLE, 3'd0, 12'd7, 12'd9, 12'd0, 1, 1'b1, NO_POINT},
    '{ROW_ITEM, tpqm_pkg::CMD_SAMPLE, 3'd0, 12'd7, 12'd9, 12'd1, 1, 1'b1, NO_POINT},
    '{ROW_ITEM, tpqm_pkg::CMD_SAMPLE, 3'd0, 12'd4095, 12'd4095, 12'd1, 1, 1'b1,
      '{1'b1, 12'd1, 12'd1}},
    '{ROW_REG, tpqm_pkg::CMD_TICK, REG_UNUSED, 12'd4095, 12'd0, 12'd0, 1, 1'b0, NO_POINT},
    '{ROW_REG, tpqm_pkg::CMD_TICK, tpqm_pkg::REG_CAL_X_LOW, 12'd4095, 12'd0, 12'd0, 1, 1'b0,
      NO_POINT},
    '{ROW_REG, tpqm_pkg::CMD_TICK, tpqm_pkg::REG_CAL_X_HIGH, 12'd0, 12'd0, 12'd0, 1, 1'b0,
      NO_POINT},
    '{ROW_REG, tpqm_pkg::CMD_TICK, tpqm_pkg::REG_CAL_Y_LOW, 12'd4095, 12'd0, 12'd0, 1, 1'b0,
      NO_POINT},
    '{ROW_REG, tpqm_pkg::CMD_TICK, tpqm_pkg::REG_CAL_Y_HIGH, 12'd0, 12'd0, 12'd0, 1, 1'b0,
      NO_POINT},
    '{ROW_ITEM, tpqm_pkg::CMD_SAMPLE, 3'd0, 12'd1000, 12'd1000, 12'd4095, 1, 1'b0, NO_POINT},
    '{ROW_ITEM, tpqm_pkg::CMD_SAMPLE, 3'd0, 12'd1000, 12'd1000, 12'd4095, 1, 1'b0, NO_POINT},
    '{ROW_ITEM, tpqm_pkg::CMD_SAMPLE, 3'd0, 12'd0, 12'd4095, 12'd4095, 1, 1'b0, NO_POINT},
    '{ROW_ITEM, tpqm_pkg::CMD_SAMPLE, 3'd0, 12'd0, 12'd4095, 12'd4095, 1, 1'b0, NO_POINT}
  };

  // Linear map of v from [a,b] onto [1,top] with truncating signed division,
  // clamped afterward. A zero span maps everything to 1.
  function automatic logic [SW-1:0] map_axis(input logic [SW-1:0] v,
                                             input logic [SW-1:0] a,
                                             input logic [SW-1:0] b,
                                             input int top);
    int vi, ai, bi, span, r;
    vi = int'(v);
    ai = int'(a);
    bi = int'(b);
    span = bi - ai;
    if (span == 0) return 12'd1;
    r = (vi - ai) * (top - 1) / span + 1;
    if (r < 1) r = 1;
    if (r > top) r = top;
    return r[SW-1:0];
  endfunction

  function automatic void reset_shadow();
    cal_x_lo     = tpqm_pkg::RST_CAL_X_LOW;
    cal_x_hi     = tpqm_pkg::RST_CAL_X_HIGH;
    cal_y_lo     = tpqm_pkg::RST_CAL_Y_LOW;
    cal_y_hi     = tpqm_pkg::RST_CAL_Y_HIGH;
    press_thr    = tpqm_pkg::RST_PRESS_THR;
    hold_ticks   = tpqm_pkg::RST_HOLDOFF;
    raw_sel      = 1'b0;
    holdoff_left = '0;
    armed        = 1'b0;
  endfunction

  function automatic void shadow_write(input logic [IW-1:0] idx,
                                       input logic [SW-1:0] data);
    case (idx)
      tpqm_pkg::REG_CAL_X_LOW:  cal_x_lo   = data;
      tpqm_pkg::REG_CAL_X_HIGH: cal_x_hi   = data;
      tpqm_pkg::REG_CAL_Y_LOW:  cal_y_lo   = data;
      tpqm_pkg::REG_CAL_Y_HIGH: cal_y_hi   = data;
      tpqm_pkg::REG_PRESS_THR:  press_thr  = data;
      tpqm_pkg::REG_HOLDOFF:    hold_ticks = data[HW-1:0];
      tpqm_pkg::REG_RAW_MODE:   raw_sel    = data[0];
      default: ;
    endcase
  endfunction

  // Advances the shadow state by one item; a sample always yields a point.
  function automatic void qualify_point(input logic cmd, input logic [SW-1:0] sx,
                                        input logic [SW-1:0] sy,
                                        input logic [SW-1:0] sp,
                                        output logic gives, output touch_result_t res);
    logic pressed;
    res = '0;
    gives = (cmd == tpqm_pkg::CMD_SAMPLE);
    pressed = sp > press_thr;
    if (cmd == tpqm_pkg::CMD_TICK) begin
      if (holdoff_left != '0) holdoff_left = holdoff_left - HW'(1);
    end else if (holdoff_left != '0) begin
      // Ignored during holdoff.
    end else if (!armed) begin
      armed = pressed;
    end else begin
      armed = 1'b0;
      if (pressed) begin
        holdoff_left = hold_ticks;
        res.touched = 1'b1;
        if (raw_sel) begin
          res.point_x = sx;
          res.point_y = sy;
        end else begin
          res.point_x = map_axis(sy, cal_y_lo, cal_y_hi, int'(tpqm_pkg::WIDTH));
          res.point_y = map_axis(sx, cal_x_hi, cal_x_lo, int'(tpqm_pkg::HEIGHT));
        end
      end
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [SW-1:0] pick_coord(input logic [SW-1:0] anchor);
    int r, v;
    r = $urandom_range(0, 99);
    if (r < 10) return 12'd0;
    if (r < 20) return 12'hFFF;
    if (r < 40) begin
      v = $urandom_range(0, 6);
      v = v + int'(anchor) - 3;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[SW-1:0];
    end
    return SW'($urandom_range(0, 4095));
  endfunction

  function automatic logic [SW-1:0] pick_pressed();
    if (press_thr == 12'hFFF) return 12'hFFF;
    return SW'($urandom_range(int'(press_thr) + 1, 4095));
  endfunction

  task automatic send_item(input logic cmd, input logic [SW-1:0] sx,
                           input logic [SW-1:0] sy, input logic [SW-1:0] sp,
                           input logic typed, input touch_result_t want);
    int gap;
    logic gives;
    touch_result_t res;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.cmd             <= cmd;
    in_ch.sample_x        <= sx;
    in_ch.sample_y        <= sy;
    in_ch.sample_pressure <= sp;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    qualify_point(cmd, sx, sy, sp, gives, res);
    if (gives) begin
      expected_points.push_back(typed ? want : res);
    end
  endtask

  task automatic send_random(input logic cmd, input logic [SW-1:0] sp);
    logic [SW-1:0] sx, sy;
    sx = pick_coord($urandom_range(0, 1) ? cal_x_lo : cal_x_hi);
    sy = pick_coord($urandom_range(0, 1) ? cal_y_lo : cal_y_hi);
    send_item(cmd, sx, sy, sp, 1'b0, '0);
  endtask

  // The sender holds off until every point has come back and the block has
  // had time to finish a trailing tick.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [SW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    shadow_write(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_phase(input int ph);
    logic [SW-1:0] xl, xh, yl, yh, thr;
    logic [HW-1:0] hold;
    logic          raw;
    int            m;
    wait_idle();
    no_idle = (ph % 5 == 2);
    m = $urandom_range(0, 3);
    xl = SW'($urandom_range(0, 4095));
    xh = SW'($urandom_range(0, 4095));
    yl = SW'($urandom_range(0, 4095));
    yh = SW'($urandom_range(0, 4095));
    if (ph == 0) begin
      xl = 12'd0; xh = 12'hFFF; yl = 12'd0; yh = 12'hFFF;
    end else if (ph == 1) begin
      xl = 12'hFFF; xh = 12'd0; yl = 12'hFFF; yh = 12'd0;
    end else if (ph == 8) begin
      xl = tpqm_pkg::RST_CAL_X_LOW; xh = tpqm_pkg::RST_CAL_X_HIGH;
      yl = tpqm_pkg::RST_CAL_Y_LOW; yh = tpqm_pkg::RST_CAL_Y_HIGH;
    end else if (m < 2) begin
      xl = SW'($urandom_range(0, 600)); xh = SW'($urandom_range(3400, 4095));
      yl = SW'($urandom_range(0, 600)); yh = SW'($urandom_range(3400, 4095));
    end else if (m == 3) begin
      if ($urandom_range(0, 1)) xh = xl;
      else yh = yl;
    end
    if (ph == 4) thr = 12'hFFF;
    else if (ph == 5) thr = 12'd0;
    else thr = SW'($urandom_range(0, 3500));
    if (ph == 3) hold = tpqm_pkg::RST_HOLDOFF;
    else if ($urandom_range(0, 4) == 0) hold = HW'($urandom_range(5, 40));
    else hold = HW'($urandom_range(0, 3));
    raw = (ph == 2) ? 1'b1 : (ph < 2) ? 1'b0 : 1'($urandom_range(0, 1));
    write_reg(tpqm_pkg::REG_CAL_X_LOW, xl);
    write_reg(tpqm_pkg::REG_CAL_X_HIGH, xh);
    write_reg(tpqm_pkg::REG_CAL_Y_LOW, yl);
    write_reg(tpqm_pkg::REG_CAL_Y_HIGH, yh);
    write_reg(tpqm_pkg::REG_PRESS_THR, thr);
    // Upper data bits beyond a register's width must be dropped.
    write_reg(tpqm_pkg::REG_HOLDOFF, {2'($urandom_range(0, 3)), hold});
    write_reg(tpqm_pkg::REG_RAW_MODE, {11'($urandom_range(0, 2047)), raw});
    if (ph == 7) write_reg(REG_UNUSED, SW'($urandom_range(0, 4095)));
  endtask

  task automatic run_phase();
    int start, r, n;
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        if (holdoff_left != '0) begin
          if ($urandom_range(0, 3) == 0) send_random(tpqm_pkg::CMD_SAMPLE, pick_pressed());
          n = int'(holdoff_left) + $urandom_range(0, 2);
          repeat (n) send_random(tpqm_pkg::CMD_TICK, SW'($urandom_range(0, 4095)));
        end
        send_random(tpqm_pkg::CMD_SAMPLE, pick_pressed());
        if ($urandom_range(0, 99) < 85) begin
          send_random(tpqm_pkg::CMD_SAMPLE, pick_pressed());
        end else begin
          send_random(tpqm_pkg::CMD_SAMPLE, SW'($urandom_range(0, int'(press_thr))));
        end
      end else if (r < 85) begin
        if ($urandom_range(0, 1)) begin
          send_random(tpqm_pkg::CMD_SAMPLE, SW'($urandom_range(0, 4095)));
        end else begin
          send_random(tpqm_pkg::CMD_SAMPLE, press_thr + SW'($urandom_range(0, 1)));
        end
      end else begin
        repeat ($urandom_range(1, 3))
          send_random(tpqm_pkg::CMD_TICK, SW'($urandom_range(0, 4095)));
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d points outstanding", $time, expected_points.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (no_idle || $urandom_range(0, 99) < 70) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_point = '{out_ch.touched, out_ch.point_x, out_ch.point_y};
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point touched=%0d x=%0d y=%0d", $time,
                 got_point.touched, got_point.point_x, got_point.point_y);
        errors++;
      end else begin
        want_point = expected_points.pop_front();
        if (got_point !== want_point) begin
          $display("%0t: expected touched=%0d x=%0d y=%0d, got touched=%0d x=%0d y=%0d",
                   $time, want_point.touched, want_point.point_x, want_point.point_y,
                   got_point.touched, got_point.point_x, got_point.point_y);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    in_ch.valid           = 1'b0;
    in_ch.cmd             = tpqm_pkg::CMD_TICK;
    in_ch.sample_x        = '0;
    in_ch.sample_y        = '0;
    in_ch.sample_pressure = '0;
    out_ch.ready          = 1'b0;
    reset_shadow();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_STEPS; i++) begin
      if (steps[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(steps[i].reg_idx, steps[i].x);
      end else begin
        repeat (steps[i].reps)
          send_item(steps[i].cmd, steps[i].x, steps[i].y, steps[i].p,
                    steps[i].typed, steps[i].want);
      end
    end

    items_sent = 0;
    for (int ph = 0; items_sent < RANDOM_ITEMS; ph++) begin
      program_phase(ph);
      run_phase();
    end

    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== touch_point_qualify_and_map.f =====
hdl/tpqm_pkg.sv
hdl/tpqm_if.sv
hdl/touch_point_qualify_and_map.sv
hdl/tpqm_checker.sv
verif/tb_touch_point_qualify_and_map.sv
